### src/bdq_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bdq_pkg: shared types and codes for the bounded deque engine
// Request modes, status codes and the per-cell update command.
// ---------------------------------------------------------------------------
package bdq_pkg;

    localparam logic [2:0] MODE_HEAD_PUT    = 3'd0;
    localparam logic [2:0] MODE_TAIL_PUT    = 3'd1;
    localparam logic [2:0] MODE_HEAD_GET    = 3'd2;
    localparam logic [2:0] MODE_TAIL_GET    = 3'd3;
    localparam logic [2:0] MODE_HEAD_ITH    = 3'd4;
    localparam logic [2:0] MODE_TAIL_ITH    = 3'd5;
    localparam logic [2:0] MODE_HEAD_REMOVE = 3'd6;
    localparam logic [2:0] MODE_TAIL_REMOVE = 3'd7;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_RANGE   = 3'd3;
    localparam logic [2:0] ST_NOMATCH = 3'd4;

    localparam logic [4:0] CAPACITY_RESET = 5'd16;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } t_cell_op;

endpackage
`default_nettype wire

### src/bdq_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bdq_cell: one storage slot of the deque chain
// Holds one word, loads it or takes a neighbor's word, and flags a match.
// ---------------------------------------------------------------------------
module bdq_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                    i_clk,
    input  bdq_pkg::t_cell_op      i_op,
    input  wire [DATA_WIDTH-1:0]   i_left,
    input  wire [DATA_WIDTH-1:0]   i_right,
    input  wire [DATA_WIDTH-1:0]   i_value,
    output logic [DATA_WIDTH-1:0]  o_data,
    output logic                   o_match
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        unique case (i_op)
            bdq_pkg::CELL_LOAD:       n_data = i_value;
            bdq_pkg::CELL_FROM_LEFT:  n_data = i_left;
            bdq_pkg::CELL_FROM_RIGHT: n_data = i_right;
            default:                  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_value);

endmodule
`default_nettype wire

### src/bounded_deque_engine.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bounded_deque_engine: bounded double-ended queue on a chain of cells
// Put/get at either end, indexed read and remove by value, with status.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the mode, tdata the
//   value and the index. Each request yields exactly one result transaction
//   on m_axis with the data word, the status and the new length.
//   The whole request is resolved in the cycle it is accepted: the cells
//   shift, load or close up at that edge and the result is registered, so
//   the result is valid in the cycle after acceptance. One request per cycle
//   is sustained while the receiver takes each result; the output register
//   is the only stage between the channels. The match and priority select
//   across the cell row are combinational.
//   When the receiver stalls, the result is held and s_axis_tready stays
//   low until the held result is taken (it rises in the same cycle that
//   m_axis_tready is seen high). Reset empties the deque (length zero) and
//   sets capacity to 16; cell contents are not cleared. Capacity is written
//   through i_cfg_we and i_cfg_wdata; the user must write it only while
//   idle, which the block does not enforce; values above DEPTH act as DEPTH.
// ---------------------------------------------------------------------------
module bounded_deque_engine #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [4:0]  i_cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // value[31:0], index[35:32], zero pad
    input  wire  [2:0]  s_axis_tuser,   // mode[2:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata    // data_out[31:0], status[34:32], length[39:35]
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 5) ? CW : 5;

    logic                  r_out_valid;
    logic [31:0]           r_data_out;
    logic [2:0]            r_status;
    logic [4:0]            r_length;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [4:0]            r_capacity;

    logic                  accept;
    logic [2:0]            mode;
    logic [3:0]            idx;
    logic [63:0]           val_ext;
    logic [DATA_WIDTH-1:0] val;
    logic [63:0]           put_ext;
    logic [XW-1:0]         cnt_x;
    logic [XW-1:0]         lim_x;
    logic [XW-1:0]         cap_x;
    logic [XW-1:0]         idx_x;
    logic [XW-1:0]         tail_pos_x;
    logic                  full;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]      cell_match;
    bdq_pkg::t_cell_op     cell_op [DEPTH];
    bdq_pkg::t_cell_op     n_op [DEPTH];

    logic [DEPTH-1:0]      live;
    logic [DEPTH-1:0]      match;
    logic [DEPTH-1:0]      match_rev;
    logic [DEPTH-1:0]      first_rev;
    logic [DEPTH-1:0]      first_oh;
    logic [DEPTH-1:0]      last_oh;
    logic [DEPTH-1:0]      tail_oh;
    logic [DEPTH-1:0]      put_oh;
    logic [DEPTH-1:0]      sel;
    logic [DEPTH-1:0]      rm_mask;
    logic [DATA_WIDTH-1:0] sel_data;
    logic [63:0]           sel_ext;

    logic [31:0]           n_data_out;
    logic [2:0]            n_status;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign mode    = s_axis_tuser[2:0];
    assign idx     = s_axis_tdata[35:32];
    assign val_ext = {32'd0, s_axis_tdata[31:0]};
    assign val     = val_ext[DATA_WIDTH-1:0];
    assign put_ext = 64'(val);

    assign cnt_x      = XW'(r_count);
    assign cap_x      = XW'(r_capacity);
    assign lim_x      = (cap_x > XW'(DEPTH)) ? XW'(DEPTH) : cap_x;
    assign idx_x      = XW'(idx);
    assign tail_pos_x = cnt_x - XW'(1) - idx_x;
    assign full       = (cnt_x >= lim_x);

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            live[k] = (XW'(k) < cnt_x);
        end
    end

    assign match   = cell_match & live;
    assign tail_oh = live & ~(live >> 1);
    assign put_oh  = ({live[DEPTH-2:0], 1'b1}) & ~live;

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            match_rev[k] = match[DEPTH-1-k];
        end
        first_rev = match_rev & (~match_rev + DEPTH'(1));
        for (int k = 0; k < DEPTH; k++) begin
            last_oh[k] = first_rev[DEPTH-1-k];
        end
    end

    assign first_oh = match & (~match + DEPTH'(1));

    always_comb begin
        sel_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            sel_data = sel_data | (cell_data[k] & {DATA_WIDTH{sel[k]}});
        end
    end

    assign sel_ext = 64'(sel_data);
    assign rm_mask = ~(sel - DEPTH'(1));

    always_comb begin
        sel        = '0;
        n_status   = bdq_pkg::ST_OK;
        n_data_out = '0;
        n_count    = r_count;
        for (int k = 0; k < DEPTH; k++) begin
            n_op[k] = bdq_pkg::CELL_HOLD;
        end
        unique case (mode) inside
            bdq_pkg::MODE_HEAD_PUT, bdq_pkg::MODE_TAIL_PUT: begin
                if (full) begin
                    n_status = bdq_pkg::ST_FULL;
                end else begin
                    n_data_out = put_ext[31:0];
                    n_count    = r_count + CW'(1);
                    for (int k = 0; k < DEPTH; k++) begin
                        if (mode == bdq_pkg::MODE_HEAD_PUT) begin
                            n_op[k] = bdq_pkg::CELL_FROM_LEFT;
                        end else if (put_oh[k]) begin
                            n_op[k] = bdq_pkg::CELL_LOAD;
                        end
                    end
                end
            end
            bdq_pkg::MODE_HEAD_GET, bdq_pkg::MODE_TAIL_GET: begin
                if (r_count == '0) begin
                    n_status = bdq_pkg::ST_EMPTY;
                end else begin
                    sel = (mode == bdq_pkg::MODE_HEAD_GET) ? DEPTH'(1) : tail_oh;
                end
            end
            bdq_pkg::MODE_HEAD_ITH, bdq_pkg::MODE_TAIL_ITH: begin
                if (idx_x >= cnt_x) begin
                    n_status = bdq_pkg::ST_RANGE;
                end else if (mode == bdq_pkg::MODE_HEAD_ITH) begin
                    n_data_out = 32'(sel_ext);
                    sel        = DEPTH'(1) << idx_x;
                end else begin
                    sel        = DEPTH'(1) << tail_pos_x;
                end
            end
            default: begin
                if (r_count == '0) begin
                    n_status = bdq_pkg::ST_EMPTY;
                end else begin
                    sel = (mode == bdq_pkg::MODE_HEAD_REMOVE) ? first_oh : last_oh;
                    if (sel == '0) begin
                        n_status = bdq_pkg::ST_NOMATCH;
                    end
                end
            end
        endcase
        if (n_status == bdq_pkg::ST_OK && sel != '0) begin
            n_data_out = sel_ext[31:0];
            if (!(mode == bdq_pkg::MODE_HEAD_ITH || mode == bdq_pkg::MODE_TAIL_ITH)) begin
                n_count = r_count - CW'(1);
                for (int k = 0; k < DEPTH; k++) begin
                    if (rm_mask[k]) begin
                        n_op[k] = bdq_pkg::CELL_FROM_RIGHT;
                    end
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            cell_op[k] = accept ? n_op[k] : bdq_pkg::CELL_HOLD;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bdq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op[g]),
            .i_left  ((g == 0) ? val : cell_data[(g == 0) ? 0 : g - 1]),
            .i_right (cell_data[(g == DEPTH - 1) ? g : g + 1]),
            .i_value (val),
            .o_data  (cell_data[g]),
            .o_match (cell_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_capacity  <= bdq_pkg::CAPACITY_RESET;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data_out <= n_data_out;
            r_status   <= n_status;
            r_length   <= 5'(XW'(n_count));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_length, r_status, r_data_out};

endmodule
`default_nettype wire

### src/bdq_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bdq_checker: port-level checks for the bounded deque engine
// Watches the request and result channels and the reset behavior.
// ---------------------------------------------------------------------------
module bdq_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [39:0] m_axis_tdata
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted request produced no result");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[34:32] != bdq_pkg::ST_OK)
            |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("nonzero data on error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[34:32] == bdq_pkg::ST_OK
            || m_axis_tdata[34:32] == bdq_pkg::ST_EMPTY
            || m_axis_tdata[34:32] == bdq_pkg::ST_FULL
            || m_axis_tdata[34:32] == bdq_pkg::ST_RANGE
            || m_axis_tdata[34:32] == bdq_pkg::ST_NOMATCH))
        else $error("undefined status code");

endmodule

bind bounded_deque_engine bdq_checker u_bdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

### tb/tb_bounded_deque_engine.sv
// ---------------------------------------------------------------------------
// tb_bounded_deque_engine: self-checking testbench for the bounded deque
// Drives requests on s_axis, predicts every result from its own deque
// model and checks each m_axis transaction field by field, in order.
// Covers the empty deque, both ends, indexed reads, removal by value,
// full and shrunken capacity, and long random traffic with random stalls.
// ---------------------------------------------------------------------------
module tb_bounded_deque_engine;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] value;
        logic [3:0]  index;
    } t_request;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  status;
        logic [4:0]  length;
    } t_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [4:0]  i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;    // value[31:0], index[35:32], zero pad
    logic [2:0]  s_axis_tuser  = '0;    // mode[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // data_out[31:0], status[34:32], length[39:35]

    // deque model
    logic [31:0] deque_words [DEPTH];
    int unsigned held;
    logic [4:0]  capacity_reg;

    t_result     expected_results [$];
    int          error_count  = 0;
    int          cycle_count  = 0;
    bit          sender_idles   = 1'b1;
    bit          receiver_idles = 1'b1;
    int          stall_left     = 0;

    logic [31:0] value_pool [4] = '{32'h0000_0001, 32'h8000_0000,
                                    32'hA5A5_5A5A, 32'h1234_5678};

    bounded_deque_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // receiver stalls
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = pick_gap(receiver_idles);
        end
    end

    function automatic int unsigned effective_capacity();
        return (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
    endfunction

    function automatic logic [31:0] extract_at(input int unsigned pos);
        logic [31:0] w;
        w = deque_words[pos];
        for (int unsigned k = pos; k + 1 < held; k++)
            deque_words[k] = deque_words[k + 1];
        held--;
        return w;
    endfunction

    function automatic t_result predict_request(input t_request req);
        t_result     res;
        bit          found;
        int unsigned pos;
        res    = '0;
        found  = 1'b0;
        pos    = 0;
        res.status = bdq_pkg::ST_OK;
        case (req.mode)
            bdq_pkg::MODE_HEAD_PUT, bdq_pkg::MODE_TAIL_PUT: begin
                if (held >= effective_capacity()) begin
                    res.status = bdq_pkg::ST_FULL;
                end else begin
                    if (req.mode == bdq_pkg::MODE_HEAD_PUT) begin
                        for (int unsigned k = held; k > 0; k--)
                            deque_words[k] = deque_words[k - 1];
                        deque_words[0] = req.value;
                    end else begin
                        deque_words[held] = req.value;
                    end
                    held++;
                    res.data = req.value;
                end
            end
            bdq_pkg::MODE_HEAD_GET, bdq_pkg::MODE_TAIL_GET: begin
                if (held == 0)
                    res.status = bdq_pkg::ST_EMPTY;
                else
                    res.data = extract_at(req.mode == bdq_pkg::MODE_HEAD_GET ? 0 : held - 1);
            end
            bdq_pkg::MODE_HEAD_ITH, bdq_pkg::MODE_TAIL_ITH: begin
                if (req.index >= held)
                    res.status = bdq_pkg::ST_RANGE;
                else if (req.mode == bdq_pkg::MODE_HEAD_ITH)
                    res.data = deque_words[req.index];
                else
                    res.data = deque_words[held - 1 - req.index];
            end
            default: begin
                if (held == 0) begin
                    res.status = bdq_pkg::ST_EMPTY;
                end else begin
                    for (int unsigned k = 0; k < held; k++) begin
                        if (deque_words[k] == req.value &&
                            (req.mode == bdq_pkg::MODE_TAIL_REMOVE || !found)) begin
                            pos   = k;
                            found = 1'b1;
                        end
                    end
                    if (found)
                        res.data = extract_at(pos);
                    else
                        res.status = bdq_pkg::ST_NOMATCH;
                end
            end
        endcase
        res.length = held[4:0];
        return res;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result exp_res;
        t_result act_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            act_res = '{data: m_axis_tdata[31:0], status: m_axis_tdata[34:32],
                        length: m_axis_tdata[39:35]};
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h",
                         $time, m_axis_tdata);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (act_res.data !== exp_res.data) begin
                    $display("%0t data_out mismatch: expected %h, actual %h",
                             $time, exp_res.data, act_res.data);
                    error_count++;
                end
                if (act_res.status !== exp_res.status) begin
                    $display("%0t status mismatch: expected %0d, actual %0d",
                             $time, exp_res.status, act_res.status);
                    error_count++;
                end
                if (act_res.length !== exp_res.length) begin
                    $display("%0t length mismatch: expected %0d, actual %0d",
                             $time, exp_res.length, act_res.length);
                    error_count++;
                end
            end
        end
    end

    task automatic send_request(input logic [2:0] mode, input logic [31:0] value,
                                input logic [3:0] index);
        t_request req;
        int       gap;
        req = '{mode: mode, value: value, index: index};
        gap = pick_gap(sender_idles);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {4'b0, index, value};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(predict_request(req));
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [4:0] cap);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        capacity_reg = cap;
        i_cfg_we    <= 1'b0;
    endtask

    task automatic test_empty_deque();
        send_request(bdq_pkg::MODE_HEAD_GET,    32'h0, 4'd0);
        send_request(bdq_pkg::MODE_TAIL_GET,    32'hFFFF_FFFF, 4'd0);
        send_request(bdq_pkg::MODE_HEAD_ITH,    32'h0, 4'd0);
        send_request(bdq_pkg::MODE_TAIL_ITH,    32'h0, 4'd15);
        send_request(bdq_pkg::MODE_HEAD_REMOVE, 32'h0, 4'd0);
        send_request(bdq_pkg::MODE_TAIL_REMOVE, 32'hFFFF_FFFF, 4'd15);
    endtask

    task automatic test_end_ordering();
        send_request(bdq_pkg::MODE_HEAD_PUT,    32'hFFFF_FFFF, 4'd0);
        send_request(bdq_pkg::MODE_TAIL_PUT,    32'h0, 4'd0);
        send_request(bdq_pkg::MODE_HEAD_PUT,    32'hA5A5_5A5A, 4'd0);
        send_request(bdq_pkg::MODE_TAIL_PUT,    32'hA5A5_5A5A, 4'd0);
        send_request(bdq_pkg::MODE_HEAD_ITH,    32'h0, 4'd1);
        send_request(bdq_pkg::MODE_TAIL_ITH,    32'h0, 4'd1);
        send_request(bdq_pkg::MODE_HEAD_ITH,    32'h0, 4'd4);
        send_request(bdq_pkg::MODE_TAIL_REMOVE, 32'h5, 4'd0);
        send_request(bdq_pkg::MODE_HEAD_REMOVE, 32'hA5A5_5A5A, 4'd0);
        send_request(bdq_pkg::MODE_HEAD_PUT,    32'hA5A5_5A5A, 4'd0);
        send_request(bdq_pkg::MODE_TAIL_REMOVE, 32'hA5A5_5A5A, 4'd0);
        send_request(bdq_pkg::MODE_HEAD_GET,    32'h0, 4'd0);
        send_request(bdq_pkg::MODE_TAIL_GET,    32'h0, 4'd0);
    endtask

    task automatic test_capacity_limits();
        set_capacity(5'd3);
        send_request(bdq_pkg::MODE_TAIL_PUT, 32'h2, 4'd0);
        send_request(bdq_pkg::MODE_TAIL_PUT, 32'h3, 4'd0);
        send_request(bdq_pkg::MODE_TAIL_PUT, 32'h4, 4'd0);
        // shrink below the current length
        set_capacity(5'd1);
        send_request(bdq_pkg::MODE_HEAD_PUT, 32'h5, 4'd0);
        send_request(bdq_pkg::MODE_HEAD_GET, 32'h0, 4'd0);
        send_request(bdq_pkg::MODE_TAIL_GET, 32'h0, 4'd0);
        send_request(bdq_pkg::MODE_TAIL_PUT, 32'h6, 4'd0);
        send_request(bdq_pkg::MODE_TAIL_GET, 32'h0, 4'd0);
        send_request(bdq_pkg::MODE_HEAD_PUT, 32'h7, 4'd0);
        set_capacity(5'd0);
        send_request(bdq_pkg::MODE_TAIL_PUT, 32'h8, 4'd0);
        send_request(bdq_pkg::MODE_HEAD_GET, 32'h0, 4'd0);
    endtask

    task automatic test_random_traffic(input int n_items, input int put_pct);
        int          r;
        logic [2:0]  mode;
        logic [31:0] value;
        logic [3:0]  index;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < put_pct)
                mode = $urandom_range(0, 1) ? bdq_pkg::MODE_TAIL_PUT
                                            : bdq_pkg::MODE_HEAD_PUT;
            else if (r < put_pct + (100 - put_pct) / 3)
                mode = $urandom_range(0, 1) ? bdq_pkg::MODE_TAIL_GET
                                            : bdq_pkg::MODE_HEAD_GET;
            else if (r < put_pct + 2 * (100 - put_pct) / 3)
                mode = $urandom_range(0, 1) ? bdq_pkg::MODE_TAIL_ITH
                                            : bdq_pkg::MODE_HEAD_ITH;
            else
                mode = $urandom_range(0, 1) ? bdq_pkg::MODE_TAIL_REMOVE
                                            : bdq_pkg::MODE_HEAD_REMOVE;

            r = $urandom_range(0, 99);
            if (r < 30)
                value = value_pool[$urandom_range(0, 3)];
            else if (r < 65 && held > 0)
                value = deque_words[$urandom_range(0, held - 1)];
            else if (r < 75)
                value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            else
                value = $urandom;

            if ($urandom_range(0, 99) < 75 && held > 0)
                index = $urandom_range(0, held - 1);
            else
                index = $urandom_range(0, 15);

            send_request(mode, value, index);
            if (i == n_items / 2 && $urandom_range(0, 1))
                wait_for_results();
        end
    endtask

    initial begin
        for (int k = 0; k < DEPTH; k++)
            deque_words[k] = '0;
        held         = 0;
        capacity_reg = bdq_pkg::CAPACITY_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_deque();
        test_end_ordering();
        test_capacity_limits();

        set_capacity(5'd16);
        test_random_traffic(120, 45);
        wait_for_results();

        sender_idles = 1'b0;
        set_capacity(5'd31);
        test_random_traffic(100, 65);

        sender_idles   = 1'b1;
        receiver_idles = 1'b0;
        set_capacity(5'd5);
        test_random_traffic(100, 45);

        receiver_idles = 1'b1;
        set_capacity(5'd1);
        test_random_traffic(50, 50);

        set_capacity(5'd0);
        test_random_traffic(20, 50);

        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        set_capacity(5'd16);
        test_random_traffic(60, 35);

        wait_for_results();
        repeat (5) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
src/bdq_pkg.sv
src/bdq_cell.sv
src/bounded_deque_engine.sv
src/bdq_checker.sv
tb/tb_bounded_deque_engine.sv
